@@ hw/rtl/atsp_pkg.sv @@
// Types and constants for the amplifier thermal / SWR protection core.
// No dependencies; imported by amp_thermal_swr_protection_core and by the bench files.
package atsp_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ATTEN_LIMIT     = 3'd0,
    CFG_ATTEN_STEP      = 3'd1,
    CFG_POWER_FLOOR     = 3'd2,
    CFG_SWR_RETRY_POWER = 3'd3,
    CFG_TEMP_RECOVERY   = 3'd4,
    CFG_TEMP_HOLD_TICKS = 3'd5,
    CFG_SWR_HOLD_TICKS  = 3'd6
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [9:0]  ATTEN_LIMIT_RST     = 10'd90;
  localparam logic [7:0]  ATTEN_STEP_RST      = 8'd30;
  localparam logic [9:0]  POWER_FLOOR_RST     = 10'd300;
  localparam logic [9:0]  SWR_RETRY_POWER_RST = 10'd310;
  localparam logic [11:0] TEMP_RECOVERY_RST   = 12'd0;
  localparam logic [15:0] TEMP_HOLD_RST       = 16'd250;
  localparam logic [15:0] SWR_HOLD_RST        = 16'd150;

  localparam logic [9:0]  ATTEN_MAX           = 10'd1023;

  // Input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [1:0] {
    TS_NORMAL  = 2'd0,
    TS_BACKOFF = 2'd1,
    TS_MUTED   = 2'd2
  } temp_state_t;

  typedef enum logic [1:0] {
    SS_NORMAL = 2'd0,
    SS_WAIT   = 2'd1,
    SS_RETRY  = 2'd2
  } swr_state_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_START = 2'd2
  } amp_action_t;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  user_target_power;
    logic        temp_alarm;
    logic        swr_alarm;
    logic [11:0] temperature;
    logic        system_stopped;
    logic        amp_is_stopped;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  target_power;
    logic        amp_off;
    amp_action_t amp_action;
    logic        retry_period;
    temp_state_t temp_mode;
    swr_state_t  swr_mode;
    logic [9:0]  extra_atten_out;
  } out_item_t;

endpackage

@@ hw/rtl/amp_thermal_swr_protection_core.sv @@
// Amplifier protection core: thermal backoff machine and SWR mute/retry machine.
// Depends on atsp_pkg (payload structs, state enums, register indexes).
//
//   Channel | Ports                          | Direction | Moves
//   --------+--------------------------------+-----------+-------------------------
//   in      | in_valid, in_stall, in_data    | into core | tick or evaluate item
//   out     | out_valid, out_stall, out_data | out       | one result per evaluate
//   cfg     | cfg_we, cfg_index, cfg_data    | into core | register write, no wait
//
// The state update and the result of an item are formed by a single layer of
// compares, one 11-bit add and one subtract, and the result lands in the output
// register at the edge of the transfer. Sustained rate is one item per clock while
// the result side keeps up. Ticks return no result.
// Reset (rst_n low, synchronous) clears both machines, the timers and the output
// valid flag and loads the register defaults; no item transfers during reset.
// Stall on the input rises only during reset or while a result sits in the output
// register and the result side stalls it.
module amp_thermal_swr_protection_core
  import atsp_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  // configuration port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [9:0]  atten_limit_r;
  logic [7:0]  atten_step_r;
  logic [9:0]  power_floor_r;
  logic [9:0]  swr_retry_power_r;
  logic [11:0] temp_recovery_r;
  logic [15:0] temp_hold_ticks_r;
  logic [15:0] swr_hold_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atten_limit_r     <= ATTEN_LIMIT_RST;
      atten_step_r      <= ATTEN_STEP_RST;
      power_floor_r     <= POWER_FLOOR_RST;
      swr_retry_power_r <= SWR_RETRY_POWER_RST;
      temp_recovery_r   <= TEMP_RECOVERY_RST;
      temp_hold_ticks_r <= TEMP_HOLD_RST;
      swr_hold_ticks_r  <= SWR_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ATTEN_LIMIT:     atten_limit_r     <= cfg_data[9:0];
        CFG_ATTEN_STEP:      atten_step_r      <= cfg_data[7:0];
        CFG_POWER_FLOOR:     power_floor_r     <= cfg_data[9:0];
        CFG_SWR_RETRY_POWER: swr_retry_power_r <= cfg_data[9:0];
        CFG_TEMP_RECOVERY:   temp_recovery_r   <= cfg_data[11:0];
        CFG_TEMP_HOLD_TICKS: temp_hold_ticks_r <= cfg_data;
        CFG_SWR_HOLD_TICKS:  swr_hold_ticks_r  <= cfg_data;
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic in_xfer;
  logic eval_xfer;
  logic tick_xfer;
  logic out_valid_r;

  assign in_stall  = !rst_n || (out_valid_r && out_stall);
  assign in_xfer   = in_valid && !in_stall;
  assign eval_xfer = in_xfer && (in_data.cmd == CMD_EVAL);
  assign tick_xfer = in_xfer && (in_data.cmd == CMD_TICK);

  // Evaluations that change state: not while the system is halted
  logic run;
  assign run = eval_xfer && !in_data.system_stopped;

  // ---------------------------------------------------------------------------
  // Machine state
  // ---------------------------------------------------------------------------
  temp_state_t           temp_state_r, temp_state_nxt;
  swr_state_t            swr_state_r, swr_state_nxt;
  logic                  temp_mute_r, temp_mute_nxt;
  logic                  swr_mute_r, swr_mute_nxt;
  logic [9:0]            temp_power_r, temp_power_nxt;
  logic [9:0]            swr_power_r, swr_power_nxt;
  logic [9:0]            extra_atten_r, extra_atten_nxt;
  logic [TIMER_BITS-1:0] temp_timer_r, temp_timer_nxt;
  logic [TIMER_BITS-1:0] swr_timer_r, swr_timer_nxt;
  logic                  retry_nxt;

  // Hold reload values, truncated or zero-extended to the timer width
  logic [TIMER_BITS-1:0] temp_reload;
  logic [TIMER_BITS-1:0] swr_reload;
  assign temp_reload = TIMER_BITS'(temp_hold_ticks_r);
  assign swr_reload  = TIMER_BITS'(swr_hold_ticks_r);

  // Thermal step arithmetic
  logic [10:0] atten_sum;
  logic [10:0] power_diff;   // bit 10 set on borrow
  logic [9:0]  stepped_power;
  assign atten_sum  = {1'b0, extra_atten_r} + {3'b000, atten_step_r};
  assign power_diff = {1'b0, temp_power_r} - {3'b000, atten_step_r};
  assign stepped_power = (power_diff[10] || (power_diff[9:0] < power_floor_r)) ?
                         power_floor_r : power_diff[9:0];

  // Thermal machine next state
  always_comb begin
    temp_state_nxt  = temp_state_r;
    temp_mute_nxt   = temp_mute_r;
    temp_power_nxt  = temp_power_r;
    extra_atten_nxt = extra_atten_r;
    temp_timer_nxt  = temp_timer_r;
    if (tick_xfer) begin
      if (temp_timer_r != '0) temp_timer_nxt = temp_timer_r - TIMER_BITS'(1);
    end else if (run) begin
      unique case (temp_state_r)
        TS_BACKOFF: begin
          temp_mute_nxt = 1'b0;
          if (temp_timer_r == '0) begin
            if ((extra_atten_r > atten_limit_r) || !in_data.temp_alarm) begin
              temp_state_nxt = TS_MUTED;
            end else begin
              extra_atten_nxt = atten_sum[10] ? ATTEN_MAX : atten_sum[9:0];
              temp_power_nxt  = stepped_power;
              temp_timer_nxt  = temp_reload;
            end
          end
        end
        TS_MUTED: begin
          temp_mute_nxt   = 1'b1;
          extra_atten_nxt = '0;
          if (in_data.temperature < temp_recovery_r) temp_state_nxt = TS_NORMAL;
        end
        default: begin
          temp_mute_nxt  = 1'b0;
          temp_power_nxt = in_data.user_target_power;
          temp_state_nxt = in_data.temp_alarm ? TS_BACKOFF : TS_NORMAL;
        end
      endcase
    end
  end

  // SWR machine next state
  always_comb begin
    swr_state_nxt = swr_state_r;
    swr_mute_nxt  = swr_mute_r;
    swr_power_nxt = swr_power_r;
    swr_timer_nxt = swr_timer_r;
    retry_nxt     = 1'b0;
    if (tick_xfer) begin
      if (swr_timer_r != '0) swr_timer_nxt = swr_timer_r - TIMER_BITS'(1);
    end else if (run) begin
      unique case (swr_state_r)
        SS_WAIT: begin
          swr_mute_nxt = 1'b1;
          if (swr_timer_r == '0) begin
            swr_state_nxt = SS_RETRY;
            swr_timer_nxt = swr_reload;
          end
        end
        SS_RETRY: begin
          if (!swr_mute_r) begin
            // retry ran one evaluation: settle or mute again
            if (!in_data.swr_alarm) begin
              swr_state_nxt = SS_NORMAL;
            end else begin
              swr_state_nxt = SS_WAIT;
              swr_mute_nxt  = 1'b1;
            end
          end else begin
            swr_mute_nxt  = 1'b0;
            swr_power_nxt = swr_retry_power_r;
            retry_nxt     = 1'b1;
          end
        end
        default: begin
          swr_power_nxt = in_data.user_target_power;
          swr_mute_nxt  = in_data.swr_alarm;
          swr_state_nxt = in_data.swr_alarm ? SS_WAIT : SS_NORMAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_state_r  <= TS_NORMAL;
      swr_state_r   <= SS_NORMAL;
      temp_mute_r   <= 1'b0;
      swr_mute_r    <= 1'b0;
      temp_power_r  <= '0;
      swr_power_r   <= '0;
      extra_atten_r <= '0;
      temp_timer_r  <= '0;
      swr_timer_r   <= '0;
    end else begin
      temp_state_r  <= temp_state_nxt;
      swr_state_r   <= swr_state_nxt;
      temp_mute_r   <= temp_mute_nxt;
      swr_mute_r    <= swr_mute_nxt;
      temp_power_r  <= temp_power_nxt;
      swr_power_r   <= swr_power_nxt;
      extra_atten_r <= extra_atten_nxt;
      temp_timer_r  <= temp_timer_nxt;
      swr_timer_r   <= swr_timer_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result forming: built from the updated state (unchanged when halted)
  // ---------------------------------------------------------------------------
  out_item_t out_data_nxt;
  out_item_t out_data_r;
  logic      out_valid_nxt;
  logic      off_nxt;

  always_comb begin
    off_nxt = temp_mute_nxt || swr_mute_nxt;
    out_data_nxt.target_power    = (temp_power_nxt < swr_power_nxt) ?
                                   temp_power_nxt : swr_power_nxt;
    out_data_nxt.amp_off         = off_nxt;
    out_data_nxt.retry_period    = retry_nxt;
    out_data_nxt.temp_mode       = temp_state_nxt;
    out_data_nxt.swr_mode        = swr_state_nxt;
    out_data_nxt.extra_atten_out = extra_atten_nxt;
    if (!run) begin
      out_data_nxt.amp_action = ACT_NONE;
    end else if (off_nxt && !in_data.amp_is_stopped) begin
      out_data_nxt.amp_action = ACT_STOP;
    end else if (!off_nxt && in_data.amp_is_stopped) begin
      out_data_nxt.amp_action = ACT_START;
    end else begin
      out_data_nxt.amp_action = ACT_NONE;
    end
  end

  // Load on an evaluate transfer, drop once the result is taken, else hold
  always_comb begin
    if (eval_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    eval_xfer |=> out_valid_r)
    else $error("evaluate transfer did not load a result");

  a_stop_needs_mute: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.amp_action == ACT_STOP) |-> out_data_r.amp_off)
    else $error("stop command without mute request");

  a_retry_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.retry_period) |-> (out_data_r.swr_mode == SS_RETRY))
    else $error("retry flagged outside retry state");

  a_tick_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_xfer && temp_timer_r != '0) |=>
      (temp_timer_r == $past(temp_timer_r) - TIMER_BITS'(1)))
    else $error("thermal hold timer did not count down on tick");

endmodule

@@ bench/atsp_bench_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard class for the amplifier protection bench: a model of both protection
// machines, the register copies they use and the queue of results still owed.
// Depends on atsp_pkg for the payload structs, state enums and register indexes.
package atsp_bench_pkg;
  import atsp_pkg::*;

  class protection_scoreboard;
    // register copies
    logic [9:0]  atten_limit;
    logic [7:0]  atten_step;
    logic [9:0]  power_floor;
    logic [9:0]  swr_retry_power;
    logic [11:0] temp_recovery;
    logic [15:0] temp_hold;
    logic [15:0] swr_hold;

    // machine state
    temp_state_t tstate;
    swr_state_t  sstate;
    bit          tmute;
    bit          smute;
    logic [9:0]  tpower;
    logic [9:0]  spower;
    logic [9:0]  xatten;
    logic [15:0] ttimer;
    logic [15:0] stimer;

    out_item_t   owed_results[$];
    int          failures;
    int          ticks;
    int          evals;
    int          checked;
    int          retries;
    int          thermal_mutes;

    function new();
      atten_limit     = ATTEN_LIMIT_RST;
      atten_step      = ATTEN_STEP_RST;
      power_floor     = POWER_FLOOR_RST;
      swr_retry_power = SWR_RETRY_POWER_RST;
      temp_recovery   = TEMP_RECOVERY_RST;
      temp_hold       = TEMP_HOLD_RST;
      swr_hold        = SWR_HOLD_RST;
      tstate = TS_NORMAL;
      sstate = SS_NORMAL;
      tmute  = 1'b0;
      smute  = 1'b0;
      tpower = '0;
      spower = '0;
      xatten = '0;
      ttimer = '0;
      stimer = '0;
    endfunction

    function void write_cfg(cfg_idx_t idx, logic [15:0] d);
      case (idx)
        CFG_ATTEN_LIMIT:     atten_limit     = d[9:0];
        CFG_ATTEN_STEP:      atten_step      = d[7:0];
        CFG_POWER_FLOOR:     power_floor     = d[9:0];
        CFG_SWR_RETRY_POWER: swr_retry_power = d[9:0];
        CFG_TEMP_RECOVERY:   temp_recovery   = d[11:0];
        CFG_TEMP_HOLD_TICKS: temp_hold       = d;
        CFG_SWR_HOLD_TICKS:  swr_hold        = d;
        default: ;
      endcase
    endfunction

    function bit amp_off_now();
      return tmute | smute;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Advance the model by one accepted transfer; queue a result for evaluations.
    function void note_input(in_item_t it);
      out_item_t   want;
      amp_action_t act;
      bit          off;
      bit          retry;
      int          p;
      logic [10:0] sum;
      if (it.cmd == CMD_TICK) begin
        ticks++;
        if (ttimer != 0) ttimer = ttimer - 16'd1;
        if (stimer != 0) stimer = stimer - 16'd1;
        return;
      end
      evals++;
      act   = ACT_NONE;
      retry = 1'b0;
      if (!it.system_stopped) begin
        case (tstate)
          TS_BACKOFF: begin
            tmute = 1'b0;
            if (ttimer == 0) begin
              if (xatten > atten_limit || !it.temp_alarm) begin
                tstate = TS_MUTED;
              end else begin
                sum    = {1'b0, xatten} + {3'b000, atten_step};
                xatten = (sum > {1'b0, ATTEN_MAX}) ? ATTEN_MAX : sum[9:0];
                p = int'(tpower) - int'(atten_step);
                if (p < int'(power_floor)) p = int'(power_floor);
                tpower = p[9:0];
                ttimer = temp_hold;
              end
            end
          end
          TS_MUTED: begin
            tmute  = 1'b1;
            xatten = '0;
            if (it.temperature < temp_recovery) tstate = TS_NORMAL;
          end
          default: begin
            tmute  = 1'b0;
            tpower = it.user_target_power;
            tstate = it.temp_alarm ? TS_BACKOFF : TS_NORMAL;
          end
        endcase

        case (sstate)
          SS_WAIT: begin
            smute = 1'b1;
            if (stimer == 0) begin
              sstate = SS_RETRY;
              stimer = swr_hold;
            end
          end
          SS_RETRY: begin
            if (!smute) begin
              if (!it.swr_alarm) begin
                sstate = SS_NORMAL;
              end else begin
                sstate = SS_WAIT;
                smute  = 1'b1;
              end
            end else begin
              smute  = 1'b0;
              spower = swr_retry_power;
              retry  = 1'b1;
            end
          end
          default: begin
            smute  = 1'b0;
            spower = it.user_target_power;
            sstate = SS_NORMAL;
            if (it.swr_alarm) begin
              sstate = SS_WAIT;
              smute  = 1'b1;
            end
          end
        endcase

        off = tmute | smute;
        if (off && !it.amp_is_stopped) act = ACT_STOP;
        else if (!off && it.amp_is_stopped) act = ACT_START;
      end
      want.target_power    = (tpower < spower) ? tpower : spower;
      want.amp_off         = tmute | smute;
      want.amp_action      = act;
      want.retry_period    = retry;
      want.temp_mode       = tstate;
      want.swr_mode        = sstate;
      want.extra_atten_out = xatten;
      owed_results.push_back(want);
    endfunction

    // Compare one accepted result against the oldest owed one.
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] result with nothing owed: tp=%0d off=%0b act=%0d", $time,
                   got.target_power, got.amp_off, got.amp_action);
        return;
      end
      want = owed_results.pop_front();
      checked++;
      if (want.retry_period) retries++;
      if (want.temp_mode == TS_MUTED) thermal_mutes++;
      if (got.target_power !== want.target_power || got.amp_off !== want.amp_off ||
          got.amp_action !== want.amp_action || got.retry_period !== want.retry_period ||
          got.temp_mode !== want.temp_mode || got.swr_mode !== want.swr_mode ||
          got.extra_atten_out !== want.extra_atten_out) begin
        failures++;
        if (failures <= 10) begin
          $display("[%0t] mismatch want tp=%0d off=%0b act=%0d rp=%0b tm=%0d sm=%0d xa=%0d",
                   $time, want.target_power, want.amp_off, want.amp_action,
                   want.retry_period, want.temp_mode, want.swr_mode, want.extra_atten_out);
          $display("           got  tp=%0d off=%0b act=%0d rp=%0b tm=%0d sm=%0d xa=%0d",
                   got.target_power, got.amp_off, got.amp_action, got.retry_period,
                   got.temp_mode, got.swr_mode, got.extra_atten_out);
        end
      end
    endfunction
  endclass

endpackage

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Top-level bench for amp_thermal_swr_protection_core: directed and random traffic
// with bursty input, patterned output stall and several register settings.
// Depends on atsp_pkg and on atsp_bench_pkg for the scoreboard class.
module testbench;
  import atsp_pkg::*;
  import atsp_bench_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 7;
  // Register setting used by the directed part; not one of the random phases.
  localparam int DIRECTED_SETTING = 7;
  localparam int IN_W = $bits(in_item_t);

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  protection_scoreboard sb;

  int cycle_count;
  int settings_used = 0;
  // Random traffic knobs, reprogrammed per phase.
  int tick_pct      = 50;
  int toggle_pct    = 8;
  bit talarm_level  = 1'b0;
  bit salarm_level  = 1'b0;
  // Receiver stall pattern state.
  int stall_mode    = 0;
  int stall_left    = 0;
  int phase_items[NUM_PHASES] = '{250, 300, 200, 250, 300, 300, 250};

  amp_thermal_swr_protection_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample both channels at the rising edge; the model advances on each input
  // transfer and each output transfer is checked against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
    end
  end

  // Receiver stall: switch at random between free running, light, heavy and
  // periodic stall.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 6);
      default: out_stall <= (stall_left % 16 < 5);
    endcase
  end

  // Build one random item. Mostly well formed: alarms persist over stretches,
  // temperature hovers around the recovery level and the amplifier status follows
  // the last mute decision. The rest is raw noise.
  function automatic in_item_t random_item();
    in_item_t                     it;
    logic [IN_W-1:0]              raw;
    int                           t;
    if ($urandom_range(0, 99) < 12) begin
      raw = IN_W'($urandom);
      it  = raw;
      return it;
    end
    if ($urandom_range(0, 99) < toggle_pct) talarm_level = !talarm_level;
    if ($urandom_range(0, 99) < toggle_pct) salarm_level = !salarm_level;
    it.cmd = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_EVAL;
    if ($urandom_range(0, 9) == 0)
      it.user_target_power = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    else
      it.user_target_power = 10'($urandom);
    it.temp_alarm = talarm_level;
    it.swr_alarm  = salarm_level;
    if ($urandom_range(0, 9) < 6) begin
      t = $urandom_range(0, 128);
      t = t - 64 + int'(sb.temp_recovery);
      if (t < 0) t = 0;
      if (t > 4095) t = 4095;
    end else begin
      t = $urandom_range(0, 4095);
    end
    it.temperature    = 12'(t);
    it.system_stopped = ($urandom_range(0, 19) == 0);
    if ($urandom_range(0, 9) == 0) it.amp_is_stopped = 1'($urandom_range(0, 1));
    else it.amp_is_stopped = sb.amp_off_now();
    return it;
  endfunction

  // Present one item and hold it until the transfer happens.
  task automatic send_item(input in_item_t it, input bit gen);
    @(negedge clk);
    if (gen) it = random_item();
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid for a gap of length n and scramble the idle payload.
  task automatic idle(input int n);
    logic [IN_W-1:0] raw;
    repeat (n) begin
      @(negedge clk);
      raw      = IN_W'($urandom);
      in_valid <= 1'b0;
      in_data  <= raw;
    end
  endtask

  // Wait until every owed result has come back, then let the core go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    sb.write_cfg(idx, val[15:0]);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Choose the register setting and traffic mix of one phase, then write all
  // seven registers.
  task automatic program_phase(input int ph);
    int v[7];
    case (ph)
      0: begin
        v = '{int'(ATTEN_LIMIT_RST), int'(ATTEN_STEP_RST), int'(POWER_FLOOR_RST),
              int'(SWR_RETRY_POWER_RST), int'(TEMP_RECOVERY_RST), int'(TEMP_HOLD_RST),
              int'(SWR_HOLD_RST)};
        tick_pct = 80; toggle_pct = 4;
      end
      1: begin
        v = '{$urandom_range(0, 300), $urandom_range(0, 100), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 4095), $urandom_range(1, 6),
              $urandom_range(1, 6)};
        tick_pct = 45; toggle_pct = 8;
      end
      2: begin
        // all minimum, including zero hold ticks: timers reload expired
        v = '{0, 0, 0, 0, 0, 0, 0};
        tick_pct = 40; toggle_pct = 8;
      end
      3: begin
        v = '{1023, 255, 1023, 1023, 4095, 1, 2};
        tick_pct = 45; toggle_pct = 5;
      end
      4: begin
        v = '{$urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 4095), $urandom_range(1, 12),
              $urandom_range(1, 12)};
        tick_pct = 50; toggle_pct = 8;
      end
      5: begin
        // high limit and big steps so the attenuation saturates
        v = '{1023, $urandom_range(100, 255), $urandom_range(0, 200),
              $urandom_range(0, 1023), $urandom_range(1000, 3000), $urandom_range(0, 3),
              $urandom_range(0, 3)};
        tick_pct = 40; toggle_pct = 3;
      end
      6: begin
        v = '{$urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 4095), 65535, 65535};
        tick_pct = 50; toggle_pct = 8;
      end
      default: begin
        v = '{40, 200, 500, 1023, 2048, 0, 1};
      end
    endcase
    for (int i = 0; i < 7; i++) write_reg(cfg_idx_t'(i), v[i]);
    settings_used++;
  endtask

  task automatic directed_item(input logic cmd, input int user, input bit ta, input bit sa,
                               input int temp, input bit sys, input bit amp);
    in_item_t it;
    it.cmd               = cmd;
    it.user_target_power = 10'(user);
    it.temp_alarm        = ta;
    it.swr_alarm         = sa;
    it.temperature       = 12'(temp);
    it.system_stopped    = sys;
    it.amp_is_stopped    = amp;
    send_item(it, 1'b0);
    idle($urandom_range(0, 2));
  endtask

  task automatic run_directed();
    // reset defaults: field extremes, a tick and a halted system
    directed_item(CMD_EVAL, 0, 0, 0, 0, 0, 0);
    directed_item(CMD_EVAL, 1023, 0, 0, 4095, 0, 1);
    directed_item(CMD_TICK, 1023, 1, 1, 4095, 1, 1);
    directed_item(CMD_EVAL, 512, 1, 1, 100, 1, 0);
    settle();
    program_phase(DIRECTED_SETTING);
    // thermal: back off with zero hold ticks, pass the limit, mute, recover
    directed_item(CMD_EVAL, 800, 1, 0, 3000, 0, 0);
    directed_item(CMD_EVAL, 800, 1, 0, 3000, 0, 0);
    directed_item(CMD_EVAL, 800, 1, 0, 3000, 0, 0);
    directed_item(CMD_EVAL, 800, 0, 0, 4095, 0, 1);
    directed_item(CMD_EVAL, 800, 0, 0, 2047, 0, 1);
    // thermal: step below the floor, floor lands above the user target
    directed_item(CMD_EVAL, 100, 1, 0, 1000, 0, 0);
    directed_item(CMD_EVAL, 100, 1, 0, 1000, 0, 0);
    // SWR: mute, wait, retry, mute again on a lasting alarm, then recover
    directed_item(CMD_EVAL, 700, 0, 1, 1000, 0, 0);
    directed_item(CMD_TICK, 700, 0, 1, 1000, 0, 0);
    directed_item(CMD_EVAL, 700, 0, 1, 1000, 0, 1);
    directed_item(CMD_EVAL, 700, 0, 1, 1000, 0, 1);
    directed_item(CMD_EVAL, 700, 0, 1, 1000, 0, 0);
    directed_item(CMD_TICK, 700, 0, 1, 1000, 0, 1);
    directed_item(CMD_TICK, 700, 0, 1, 1000, 0, 1);
    directed_item(CMD_EVAL, 700, 0, 1, 1000, 0, 1);
    directed_item(CMD_EVAL, 700, 0, 1, 1000, 0, 1);
    directed_item(CMD_EVAL, 700, 0, 0, 1000, 0, 1);
    directed_item(CMD_EVAL, 1023, 1, 1, 4095, 1, 1);
    directed_item(CMD_EVAL, 0, 0, 0, 0, 0, 1);
  endtask

  // Send n random items in bursts of random length with random gaps.
  task automatic run_random(input int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent < n) begin
          send_item('0, 1'b1);
          sent++;
        end
      end
      idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    sb        = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      program_phase(ph);
      run_random(phase_items[ph]);
    end
    settle();
    repeat (10) @(posedge clk);

    if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
    $display("Covered %0d transfers (%0d ticks, %0d evaluations) over %0d register settings",
             sb.ticks + sb.evals, sb.ticks, sb.evals, settings_used);
    $display("Checked %0d results: %0d SWR retries, %0d in thermal mute, %0d failures",
             sb.checked, sb.retries, sb.thermal_mutes, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop if the run hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/atsp_pkg.sv
hw/rtl/amp_thermal_swr_protection_core.sv
bench/atsp_bench_pkg.sv
bench/testbench.sv
